// File: hdl/mlfe_pkg.sv
// Shared types and constants for the marker/length frame extractor.
package mlfe_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 15;
  localparam int unsigned IdxW  = 3;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_START2  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_END1    = 3'd5,
    PH_END2    = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD_END = 2'd1,
    ST_TOO_BIG = 2'd2
  } status_e;

  typedef enum logic [IdxW-1:0] {
    REG_START_FIRST  = 3'd0,
    REG_START_SECOND = 3'd1,
    REG_END_FIRST    = 3'd2,
    REG_END_SECOND   = 3'd3,
    REG_MAX_PAYLOAD  = 3'd4
  } reg_idx_e;

  localparam logic [ByteW-1:0] StartFirstRst  = 8'hAA;
  localparam logic [ByteW-1:0] StartSecondRst = 8'h55;
  localparam logic [ByteW-1:0] EndFirstRst    = 8'h55;
  localparam logic [ByteW-1:0] EndSecondRst   = 8'hAA;
  localparam logic [LenW-1:0]  MaxPayloadRst  = 15'd1018;
  localparam logic [LenW-1:0]  LenSat         = {LenW{1'b1}};

  typedef struct packed {
    logic [ByteW-1:0] start_first;
    logic [ByteW-1:0] start_second;
    logic [ByteW-1:0] end_first;
    logic [ByteW-1:0] end_second;
    logic [LenW-1:0]  max_payload;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             frame_end;
    logic [1:0]       frame_status;
    logic [LenW-1:0]  frame_length;
  } res_t;

endpackage

// File: hdl/mlfe_cfg.sv
// Configuration register file: marker bytes and payload length limit.
module mlfe_cfg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [mlfe_pkg::IdxW-1:0] cfg_index_i,
  input  logic [mlfe_pkg::LenW-1:0] cfg_data_i,
  output mlfe_pkg::cfg_t          cfg_o
);
  import mlfe_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_first  <= StartFirstRst;
      cfg_q.start_second <= StartSecondRst;
      cfg_q.end_first    <= EndFirstRst;
      cfg_q.end_second   <= EndSecondRst;
      cfg_q.max_payload  <= MaxPayloadRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_START_FIRST:  cfg_q.start_first  <= cfg_data_i[ByteW-1:0];
        REG_START_SECOND: cfg_q.start_second <= cfg_data_i[ByteW-1:0];
        REG_END_FIRST:    cfg_q.end_first    <= cfg_data_i[ByteW-1:0];
        REG_END_SECOND:   cfg_q.end_second   <= cfg_data_i[ByteW-1:0];
        REG_MAX_PAYLOAD:  cfg_q.max_payload  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/mlfe_parse.sv
// Frame parser: phase machine, length capture and payload countdown.
module mlfe_parse (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     beat_i,
  input  logic [mlfe_pkg::ByteW-1:0] byte_i,
  input  mlfe_pkg::cfg_t           cfg_i,
  output logic                     res_valid_o,
  output mlfe_pkg::res_t           res_o
);
  import mlfe_pkg::*;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  len_lo_q, len_lo_d;
  logic [LenW-1:0]   decl_len_q, decl_len_d;
  logic [LenW-1:0]   remain_q, remain_d;
  logic [2*ByteW-1:0] len_full;
  logic              too_big;
  logic [LenW-1:0]   len_sat;
  logic [LenW-1:0]   remain_dec;

  assign len_full   = {byte_i, len_lo_q};
  assign too_big    = len_full > {1'b0, cfg_i.max_payload};
  assign len_sat    = len_full[2*ByteW-1] ? LenSat : len_full[LenW-1:0];
  assign remain_dec = remain_q - LenW'(1);

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_START2: begin
        if (byte_i == cfg_i.start_second)     phase_d = PH_LEN_LO;
        else if (byte_i == cfg_i.start_first) phase_d = PH_START2;
        else                                  phase_d = PH_HUNT;
      end
      PH_LEN_LO: phase_d = PH_LEN_HI;
      PH_LEN_HI: begin
        if (too_big)            phase_d = PH_HUNT;
        else if (len_full == '0) phase_d = PH_END1;
        else                    phase_d = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (remain_dec == '0) phase_d = PH_END1;
      end
      PH_END1: begin
        phase_d = (byte_i == cfg_i.end_first) ? PH_END2 : PH_HUNT;
      end
      PH_END2: phase_d = PH_HUNT;
      default: begin
        phase_d = (byte_i == cfg_i.start_first) ? PH_START2 : PH_HUNT;
      end
    endcase
  end

  // results and data register updates
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    len_lo_d    = len_lo_q;
    decl_len_d  = decl_len_q;
    remain_d    = remain_q;
    case (phase_q)
      PH_LEN_LO: len_lo_d = byte_i;
      PH_LEN_HI: begin
        if (too_big) begin
          decl_len_d         = len_sat;
          res_valid_o        = 1'b1;
          res_o.frame_end    = 1'b1;
          res_o.frame_status = ST_TOO_BIG;
          res_o.frame_length = len_sat;
        end else begin
          decl_len_d = len_full[LenW-1:0];
          remain_d   = len_full[LenW-1:0];
        end
      end
      PH_PAYLOAD: begin
        remain_d           = remain_dec;
        res_valid_o        = 1'b1;
        res_o.payload_byte = byte_i;
      end
      PH_END1: begin
        if (byte_i != cfg_i.end_first) begin
          res_valid_o        = 1'b1;
          res_o.frame_end    = 1'b1;
          res_o.frame_status = ST_BAD_END;
          res_o.frame_length = decl_len_q;
        end
      end
      PH_END2: begin
        res_valid_o        = 1'b1;
        res_o.frame_end    = 1'b1;
        res_o.frame_status = (byte_i == cfg_i.end_second) ? ST_GOOD : ST_BAD_END;
        res_o.frame_length = decl_len_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      len_lo_q   <= '0;
      decl_len_q <= '0;
      remain_q   <= '0;
    end else if (beat_i) begin
      phase_q    <= phase_d;
      len_lo_q   <= len_lo_d;
      decl_len_q <= decl_len_d;
      remain_q   <= remain_d;
    end
  end

endmodule

// File: hdl/marker_length_frame_extractor.sv
// Top level of the marker/length frame extractor with its output register.
// Takes one received byte per cycle. A byte is parsed in the cycle it is
// accepted and its result, if any (a payload byte or a closing status beat),
// appears in the output register on the next cycle. Input is stalled only
// while that single output register holds an untaken result and the output
// side stalls, so the sustained rate is one byte per clock. Each frame gives
// one beat per payload byte followed by one closing beat with status and
// declared length; frames with a non-good status should be dropped downstream.
module marker_length_frame_extractor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [mlfe_pkg::IdxW-1:0]  cfg_index_i,
  input  logic [mlfe_pkg::LenW-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [mlfe_pkg::ByteW-1:0] rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [mlfe_pkg::ByteW-1:0] payload_byte_o,
  output logic                       frame_end_o,
  output logic [1:0]                 frame_status_o,
  output logic [mlfe_pkg::LenW-1:0]  frame_length_o
);
  import mlfe_pkg::*;

  cfg_t  cfg;
  res_t  res;
  res_t  out_q;
  logic  res_valid;
  logic  out_valid_q;
  logic  beat;
  logic  out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_free;
  assign beat       = in_valid_i && out_free;

  mlfe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mlfe_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .byte_i      (rx_byte_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= beat && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && beat && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = out_q.payload_byte;
  assign frame_end_o    = out_q.frame_end;
  assign frame_status_o = out_q.frame_status;
  assign frame_length_o = out_q.frame_length;

  // closing beats never carry a payload byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> payload_byte_o == '0)
    else $error("closing beat carries payload data");

  // payload beats carry no status or length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_end_o |-> frame_status_o == ST_GOOD && frame_length_o == '0)
    else $error("payload beat carries status or length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_status_o != 2'd3)
    else $error("undefined frame status");

  // an untaken result must stay valid while the output side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

// File: test/tb_marker_length_frame_extractor.sv
// Self-checking testbench for the marker/length frame extractor: directed table plus random frames.
`timescale 1ns / 100ps

module tb_marker_length_frame_extractor;
  import mlfe_pkg::*;

  // one directed beat; closing beats with an obvious result carry it typed in
  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic             typed;
    status_e          st;
    logic [LenW-1:0]  len;
  } dir_row_t;

  localparam int DirN = 27;
  localparam dir_row_t DirRows [DirN] = '{
    // start broken by a foreign byte, then the byte is skipped while hunting
    '{8'hAA, 1'b0, ST_GOOD, 15'd0}, '{8'h12, 1'b0, ST_GOOD, 15'd0},
    // repeated first marker byte restarts; payload at both byte extremes
    '{8'hAA, 1'b0, ST_GOOD, 15'd0}, '{8'hAA, 1'b0, ST_GOOD, 15'd0},
    '{8'h55, 1'b0, ST_GOOD, 15'd0}, '{8'h02, 1'b0, ST_GOOD, 15'd0},
    '{8'h00, 1'b0, ST_GOOD, 15'd0}, '{8'h00, 1'b0, ST_GOOD, 15'd0},
    '{8'hFF, 1'b0, ST_GOOD, 15'd0}, '{8'h55, 1'b0, ST_GOOD, 15'd0},
    '{8'hAA, 1'b1, ST_GOOD, 15'd2},
    // zero length, wrong second end byte
    '{8'hAA, 1'b0, ST_GOOD, 15'd0}, '{8'h55, 1'b0, ST_GOOD, 15'd0},
    '{8'h00, 1'b0, ST_GOOD, 15'd0}, '{8'h00, 1'b0, ST_GOOD, 15'd0},
    '{8'h55, 1'b0, ST_GOOD, 15'd0}, '{8'h00, 1'b1, ST_BAD_END, 15'd0},
    // 0xFFFF is over the limit, length saturates
    '{8'hAA, 1'b0, ST_GOOD, 15'd0}, '{8'h55, 1'b0, ST_GOOD, 15'd0},
    '{8'hFF, 1'b0, ST_GOOD, 15'd0}, '{8'hFF, 1'b1, ST_TOO_BIG, 15'd32767},
    // wrong first end byte
    '{8'hAA, 1'b0, ST_GOOD, 15'd0}, '{8'h55, 1'b0, ST_GOOD, 15'd0},
    '{8'h01, 1'b0, ST_GOOD, 15'd0}, '{8'h00, 1'b0, ST_GOOD, 15'd0},
    '{8'h7E, 1'b0, ST_GOOD, 15'd0}, '{8'h12, 1'b1, ST_BAD_END, 15'd1}
  };

  logic                   clk;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [IdxW-1:0]        cfg_index_i = '0;
  logic [LenW-1:0]        cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [ByteW-1:0]       rx_byte_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [ByteW-1:0]       payload_byte_o;
  logic                   frame_end_o;
  logic [1:0]             frame_status_o;
  logic [LenW-1:0]        frame_length_o;

  marker_length_frame_extractor dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .payload_byte_o (payload_byte_o),
    .frame_end_o    (frame_end_o),
    .frame_status_o (frame_status_o),
    .frame_length_o (frame_length_o)
  );

  // deframer model state and its copy of the registers
  cfg_t             model_cfg = '{StartFirstRst, StartSecondRst, EndFirstRst, EndSecondRst,
                                  MaxPayloadRst};
  phase_e           frame_ph  = PH_HUNT;
  logic [ByteW-1:0] len_lo    = '0;
  logic [LenW-1:0]  decl_len  = '0;
  logic [LenW-1:0]  remaining = '0;

  res_t expected_beats[$];
  int   errors     = 0;
  int   bytes_fed  = 0;
  int   hold_left  = 0;
  bit   quiet      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic res_t closing(input status_e st, input logic [LenW-1:0] len);
    res_t beat;
    beat = '0;
    beat.frame_end    = 1'b1;
    beat.frame_status = st;
    beat.frame_length = len;
    return beat;
  endfunction

  // advance the deframer by one byte; returns 1 when the byte gives a beat
  function automatic bit deframe_step(input logic [ByteW-1:0] b, output res_t beat);
    logic [15:0] len;
    bit          has;
    beat = '0;
    has  = 1'b0;
    case (frame_ph)
      PH_START2: begin
        if (b == model_cfg.start_second) frame_ph = PH_LEN_LO;
        else if (b == model_cfg.start_first) frame_ph = PH_START2;
        else frame_ph = PH_HUNT;
      end
      PH_LEN_LO: begin
        len_lo   = b;
        frame_ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len = {b, len_lo};
        if (len > {1'b0, model_cfg.max_payload}) begin
          decl_len = (len > 16'h7FFF) ? LenSat : len[LenW-1:0];
          beat     = closing(ST_TOO_BIG, decl_len);
          frame_ph = PH_HUNT;
          has      = 1'b1;
        end else begin
          decl_len  = len[LenW-1:0];
          remaining = len[LenW-1:0];
          frame_ph  = (len == 16'd0) ? PH_END1 : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        remaining = remaining - 1'b1;
        if (remaining == '0) frame_ph = PH_END1;
        beat.payload_byte = b;
        has = 1'b1;
      end
      PH_END1: begin
        if (b == model_cfg.end_first) begin
          frame_ph = PH_END2;
        end else begin
          beat     = closing(ST_BAD_END, decl_len);
          frame_ph = PH_HUNT;
          has      = 1'b1;
        end
      end
      PH_END2: begin
        beat     = closing((b == model_cfg.end_second) ? ST_GOOD : ST_BAD_END, decl_len);
        frame_ph = PH_HUNT;
        has      = 1'b1;
      end
      default: frame_ph = (b == model_cfg.start_first) ? PH_START2 : PH_HUNT;
    endcase
    return has;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // output side: compare each taken beat with the oldest prediction
  always @(posedge clk) begin : beat_check
    res_t got;
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {payload_byte_o, frame_end_o, frame_status_o, frame_length_o};
      if (expected_beats.size() == 0) begin
        note_error($sformatf("unexpected beat: byte=%h end=%b st=%0d len=%0d",
                             got.payload_byte, got.frame_end, got.frame_status,
                             got.frame_length));
      end else begin
        want = expected_beats.pop_front();
        if (got.payload_byte !== want.payload_byte || got.frame_end !== want.frame_end ||
            got.frame_status !== want.frame_status ||
            got.frame_length !== want.frame_length) begin
          note_error($sformatf(
            "mismatch: exp byte=%h end=%b st=%0d len=%0d, got byte=%h end=%b st=%0d len=%0d",
            want.payload_byte, want.frame_end, want.frame_status, want.frame_length,
            got.payload_byte, got.frame_end, got.frame_status, got.frame_length));
        end
      end
    end
  end

  // receiver stall: random, or a counted hold-off when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 6);
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk); while (in_stall_o);
  endtask

  task automatic feed(input logic [ByteW-1:0] b);
    res_t beat;
    send_byte(b);
    bytes_fed++;
    if (deframe_step(b, beat)) expected_beats.push_back(beat);
  endtask

  // sender pauses until every predicted beat is out, then lets the block settle
  task automatic wait_flushed();
    @(negedge clk);
    in_valid_i <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [LenW-1:0] val);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      REG_START_FIRST:  model_cfg.start_first  = val[ByteW-1:0];
      REG_START_SECOND: model_cfg.start_second = val[ByteW-1:0];
      REG_END_FIRST:    model_cfg.end_first    = val[ByteW-1:0];
      REG_END_SECOND:   model_cfg.end_second   = val[ByteW-1:0];
      REG_MAX_PAYLOAD:  model_cfg.max_payload  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  // byte registers get junk in the unused upper data bits
  task automatic write_all(input logic [7:0] sf, input logic [7:0] ss, input logic [7:0] ef,
                           input logic [7:0] es, input logic [LenW-1:0] mx);
    write_reg(REG_START_FIRST,  {7'($urandom), sf});
    write_reg(REG_START_SECOND, {7'($urandom), ss});
    write_reg(REG_END_FIRST,    {7'($urandom), ef});
    write_reg(REG_END_SECOND,   {7'($urandom), es});
    write_reg(REG_MAX_PAYLOAD,  mx);
  endtask

  // one random chunk: mostly well-formed frames, some noise and broken frames
  task automatic send_frame();
    int          kind;
    int          pick;
    int          lim;
    int          len;
    logic [7:0]  e1;
    logic [7:0]  e2;
    kind = $urandom_range(99);
    lim  = model_cfg.max_payload;
    if (kind < 8) begin
      repeat ($urandom_range(4, 1)) feed(8'($urandom));
    end else if (kind < 12) begin
      feed(model_cfg.start_first);
      feed(8'($urandom));
    end else begin
      pick = $urandom_range(99);
      if (pick < 10) len = $urandom_range(16'hFFFF, lim + 1);
      else if (pick < 14 && lim <= 40) len = lim;
      else if (pick < 24) len = $urandom_range((lim < 40) ? lim : 40, 0);
      else len = $urandom_range((lim < 12) ? lim : 12, 0);
      feed(model_cfg.start_first);
      feed(model_cfg.start_second);
      feed(len[7:0]);
      feed(len[15:8]);
      if (len <= lim) begin
        repeat (len) feed(8'($urandom));
        e1 = model_cfg.end_first;
        e2 = model_cfg.end_second;
        pick = $urandom_range(99);
        if (pick < 5) e1 = e1 ^ 8'($urandom_range(255, 1));
        else if (pick < 10) e2 = e2 ^ 8'($urandom_range(255, 1));
        feed(e1);
        feed(e2);
      end
    end
  endtask

  initial begin : stimulus
    res_t beat;
    bit   has;
    int   first;
    logic [7:0] sb;
    logic [7:0] eb;
    repeat (4) @(negedge clk);
    rst_ni <= 1'b1;

    foreach (DirRows[i]) begin
      send_byte(DirRows[i].rx);
      bytes_fed++;
      has = deframe_step(DirRows[i].rx, beat);
      if (DirRows[i].typed) expected_beats.push_back(closing(DirRows[i].st, DirRows[i].len));
      else if (has) expected_beats.push_back(beat);
    end
    wait_flushed();

    for (int p = 0; p < 6; p++) begin
      quiet = 1'b0;
      case (p)
        1: write_all(8'h00, 8'hFF, 8'hFF, 8'h00, 15'd0);
        2: write_all(8'hFF, 8'h00, 8'h00, 8'hFF, LenSat);
        3: write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     15'($urandom_range(24, 0)));
        4: begin
          sb = 8'($urandom);
          eb = 8'($urandom);
          write_all(sb, sb, eb, eb, 15'($urandom_range(40, 0)));
        end
        5: write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), MaxPayloadRst);
        default: ;
      endcase
      // long receiver hold-off so the output register fills and input stalls
      if (p == 2) hold_left = 300;
      if (p == 3) quiet = 1'b1;
      first = bytes_fed;
      while (bytes_fed - first < 112) send_frame();
      wait_flushed();
    end

    quiet = 1'b0;
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
